[src/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue: sizes, action and
// status codes, and the payload structs of both channels and the entry store.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH    = 64;
    localparam int KEY_BITS = 16;
    localparam int ID_BITS  = 16;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int OCC_W    = 7;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_SEARCH = 2'd3;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_EMPTY     = 2'd1;
    localparam logic [1:0] STS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STS_FULL      = 2'd3;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [OCC_W-1:0]  t_occ;

    typedef struct packed {
        logic [1:0]          action;
        logic [KEY_BITS-1:0] key;
        logic [ID_BITS-1:0]  ident;
    } t_in;

    typedef struct packed {
        logic [1:0]          status;
        logic [KEY_BITS-1:0] out_key;
        logic [ID_BITS-1:0]  out_ident;
        logic [OCC_W-1:0]    occupancy;
    } t_out;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [ID_BITS-1:0]  ident;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_addr  addr;
        t_entry data;
    } t_wr_req;

endpackage

[src/spq_ram.sv]
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]         i_rd_addr,
    output logic [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer of the queue: walks the entry store one slot per cycle through a
// single compare unit, shifting entries up for an insert and down for a pop
// or remove, and holds the entry count.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  spq_pkg::t_in     i_in_data,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output spq_pkg::t_out    o_res,
    output spq_pkg::t_addr   o_rd_addr,
    input  spq_pkg::t_entry  i_rd_data,
    output spq_pkg::t_wr_req o_wr
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS     = 3'd1;
    localparam logic [2:0] S_INS_PUT = 3'd2;
    localparam logic [2:0] S_FIND    = 3'd3;
    localparam logic [2:0] S_SHIFT   = 3'd4;
    localparam logic [2:0] S_RESP    = 3'd5;

    logic [2:0]                   r_state, n_state;
    spq_pkg::t_cnt                r_cnt, n_cnt;
    spq_pkg::t_addr               r_idx, n_idx;
    logic [1:0]                   r_act, n_act;
    logic [spq_pkg::KEY_BITS-1:0] r_key, n_key;
    logic [spq_pkg::ID_BITS-1:0]  r_id, n_id;
    logic [1:0]                   r_status, n_status;
    logic [spq_pkg::KEY_BITS-1:0] r_rkey, n_rkey;
    logic [spq_pkg::ID_BITS-1:0]  r_rid, n_rid;

    spq_pkg::t_cnt  idx_inc;
    spq_pkg::t_cnt  cnt_dec;
    logic           idx_last;
    logic           key_ge;
    logic           id_match;
    spq_pkg::t_entry new_entry;

    assign idx_inc   = spq_pkg::t_cnt'(r_idx) + 1'b1;
    assign cnt_dec   = r_cnt - 1'b1;
    assign idx_last  = (idx_inc >= r_cnt);
    assign key_ge    = (i_rd_data.key >= r_key);
    assign id_match  = (r_act == spq_pkg::ACT_POP) || (i_rd_data.ident == r_id);
    assign new_entry = '{key: r_key, ident: r_id};

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_act     = r_act;
        n_key     = r_key;
        n_id      = r_id;
        n_status  = r_status;
        n_rkey    = r_rkey;
        n_rid     = r_rid;
        o_rd_addr = '0;
        o_wr      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act    = i_in_data.action;
                    n_key    = i_in_data.key;
                    n_id     = i_in_data.ident;
                    n_status = spq_pkg::STS_OK;
                    n_rkey   = '0;
                    n_rid    = '0;
                    if (i_in_data.action == spq_pkg::ACT_INSERT) begin
                        if (r_cnt == spq_pkg::t_cnt'(spq_pkg::DEPTH)) begin
                            n_status = spq_pkg::STS_FULL;
                            n_state  = S_RESP;
                        end else if (r_cnt == '0) begin
                            o_wr.en   = 1'b1;
                            o_wr.addr = '0;
                            o_wr.data = '{key: i_in_data.key, ident: i_in_data.ident};
                            n_cnt     = r_cnt + 1'b1;
                            n_state   = S_RESP;
                        end else begin
                            // start at the tail and walk toward the head
                            o_rd_addr = spq_pkg::t_addr'(cnt_dec);
                            n_idx     = spq_pkg::t_addr'(cnt_dec);
                            n_state   = S_INS;
                        end
                    end else if (r_cnt == '0) begin
                        n_status = spq_pkg::STS_EMPTY;
                        n_state  = S_RESP;
                    end else begin
                        o_rd_addr = '0;
                        n_idx     = '0;
                        n_state   = S_FIND;
                    end
                end
            end

            S_INS: begin
                if (key_ge) begin
                    // move this entry up one slot
                    o_wr.en   = 1'b1;
                    o_wr.addr = spq_pkg::t_addr'(idx_inc);
                    o_wr.data = i_rd_data;
                    if (r_idx == '0) begin
                        n_state = S_INS_PUT;
                    end else begin
                        o_rd_addr = r_idx - 1'b1;
                        n_idx     = r_idx - 1'b1;
                    end
                end else begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = spq_pkg::t_addr'(idx_inc);
                    o_wr.data = new_entry;
                    n_cnt     = r_cnt + 1'b1;
                    n_state   = S_RESP;
                end
            end

            S_INS_PUT: begin
                o_wr.en   = 1'b1;
                o_wr.addr = '0;
                o_wr.data = new_entry;
                n_cnt     = r_cnt + 1'b1;
                n_state   = S_RESP;
            end

            S_FIND: begin
                if (id_match) begin
                    n_rkey = i_rd_data.key;
                    n_rid  = i_rd_data.ident;
                    if (r_act == spq_pkg::ACT_SEARCH) begin
                        n_state = S_RESP;
                    end else if (!idx_last) begin
                        o_rd_addr = spq_pkg::t_addr'(idx_inc);
                        n_idx     = spq_pkg::t_addr'(idx_inc);
                        n_state   = S_SHIFT;
                    end else begin
                        n_cnt   = cnt_dec;
                        n_state = S_RESP;
                    end
                end else if (!idx_last) begin
                    o_rd_addr = spq_pkg::t_addr'(idx_inc);
                    n_idx     = spq_pkg::t_addr'(idx_inc);
                end else begin
                    n_status = spq_pkg::STS_NOT_FOUND;
                    n_state  = S_RESP;
                end
            end

            S_SHIFT: begin
                // close the gap: move this entry down one slot
                o_wr.en   = 1'b1;
                o_wr.addr = r_idx - 1'b1;
                o_wr.data = i_rd_data;
                if (!idx_last) begin
                    o_rd_addr = spq_pkg::t_addr'(idx_inc);
                    n_idx     = spq_pkg::t_addr'(idx_inc);
                end else begin
                    n_cnt   = cnt_dec;
                    n_state = S_RESP;
                end
            end

            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_idx    <= n_idx;
        r_act    <= n_act;
        r_key    <= n_key;
        r_id     <= n_id;
        r_status <= n_status;
        r_rkey   <= n_rkey;
        r_rid    <= n_rid;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESP);

    always_comb begin
        o_res.status    = r_status;
        o_res.out_key   = r_rkey;
        o_res.out_ident = r_rid;
        o_res.occupancy = spq_pkg::t_occ'(r_cnt);
    end

endmodule

[src/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded min-priority queue of key/ident entries kept in ascending key order.
//
// Input channel (i_in_valid/o_in_ready/i_in_data) takes one action per
// transfer: insert, pop head, remove by ident, or search by ident. Each action
// yields exactly one result transfer on the output channel
// (o_out_valid/i_out_ready/o_out_data) with status, entry and occupancy.
// Entries live in one RAM with a registered read; a sequencer walks it one
// slot per cycle through a single key/ident compare. An insert moves entries
// up from the tail until its slot is found; pop/remove/search scan from the
// head, and a pop or remove then moves the later entries down. Full, empty
// and first-insert cases need no walk. The RAM's single write and read port
// set the walking rate. No new action is accepted until the current one
// has been handed to the output register.
// Reset empties the queue at once (count cleared, no clearing pass).
// While the receiver stalls, the result waits in the output register; the
// next action may still be accepted and run, and holds in its final state
// until that register frees.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  spq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output spq_pkg::t_out o_out_data
);

    logic             res_valid;
    logic             res_ready;
    spq_pkg::t_out    res;
    spq_pkg::t_addr   rd_addr;
    spq_pkg::t_entry  rd_data;
    spq_pkg::t_wr_req wr;

    logic          r_out_valid;
    spq_pkg::t_out r_out_data;

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr       (wr)
    );

    spq_ram #(
        .WIDTH($bits(spq_pkg::t_entry)),
        .DEPTH(spq_pkg::DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr.en),
        .i_wr_addr(wr.addr),
        .i_wr_data(wr.data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // the output register frees when empty or when its result transfers
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
